FILE: sv/ccag_pkg.sv
// ----------------------------------------------------------------------------
// ccag_pkg: shared definitions for the cover crop address generator
// Field widths, register indexes and the geometry sequencer states.
// ----------------------------------------------------------------------------
package ccag_pkg;

	// Width of one coordinate or one image dimension.
	localparam int DIM_W = 7;
	// Largest value a dimension register can hold.
	localparam int DIM_MAX = (1 << DIM_W) - 1;
	// Width of the linear source index.
	localparam int INDEX_W = 13;
	// Width of the configuration register index.
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

	// Reset value of both dimension registers.
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd80;

	// Stream payload widths, padded to whole bytes.
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	// States of the crop offset sequencer.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} ccag_state_t;

endpackage

FILE: sv/ccag_geometry.sv
// ----------------------------------------------------------------------------
// ccag_geometry: dimension registers and crop offset sequencer
// Holds the source dimensions and, after every register write, derives the
// scale denominator and both crop offsets with a bit-serial divider.
// ----------------------------------------------------------------------------
module ccag_geometry #(
	parameter int TILE_SIZE = 80
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccag_pkg::DIM_W-1:0]     cfg_data,
	output logic                           busy,
	output logic [ccag_pkg::DIM_W-1:0]     w_eff,
	output logic [ccag_pkg::DIM_W-1:0]     h_eff,
	output logic [ccag_pkg::DIM_W-1:0]     den,
	output logic [$clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1)-1:0] crop_x,
	output logic [$clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1)-1:0] crop_y
);

	localparam int DW     = ccag_pkg::DIM_W;
	localparam int UP_W   = $clog2(ccag_pkg::DIM_MAX*TILE_SIZE+1);
	localparam int CROP_W = $clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1);
	localparam int CNT_W  = $clog2(UP_W);

	ccag_pkg::ccag_state_t state_q, state_nx;

	logic [DW-1:0]    width_q, height_q;
	logic [DW-1:0]    w_eff_q, h_eff_q, den_q;
	logic [CROP_W-1:0] crop_x_q, crop_y_q;
	logic [UP_W-1:0]  num_x_q, num_y_q;
	logic [DW-1:0]    rem_x_q, rem_y_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DW-1:0]    w_use, h_use;
	logic [DW:0]      trial_x, trial_y;
	logic             ge_x, ge_y;
	logic [UP_W-1:0]  up_x_less, up_y_less;

	// A zero dimension is treated as one pixel.
	assign w_use = (width_q == '0) ? DW'(1) : width_q;
	assign h_use = (height_q == '0) ? DW'(1) : height_q;

	// One restoring division step per cycle on each axis.
	assign trial_x = {rem_x_q, num_x_q[UP_W-1]};
	assign trial_y = {rem_y_q, num_y_q[UP_W-1]};
	assign ge_x    = trial_x >= {1'b0, den_q};
	assign ge_y    = trial_y >= {1'b0, den_q};

	// Upscaled length minus the tile, halved below to give the crop offset.
	assign up_x_less = num_x_q - UP_W'(TILE_SIZE);
	assign up_y_less = num_y_q - UP_W'(TILE_SIZE);

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ccag_pkg::DIM_RESET;
			height_q <= ccag_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ccag_pkg::REG_SRC_WIDTH:  width_q  <= cfg_data;
				ccag_pkg::REG_SRC_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccag_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state: every write restarts the derivation.
	always_comb begin
		state_nx = state_q;
		busy     = 1'b1;
		case (state_q)
			ccag_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (cfg_we) state_nx = ccag_pkg::ST_LOAD;
			end
			ccag_pkg::ST_LOAD: begin
				state_nx = ccag_pkg::ST_DIV;
			end
			ccag_pkg::ST_DIV: begin
				if (cnt_q == '0) state_nx = ccag_pkg::ST_FINISH;
			end
			ccag_pkg::ST_FINISH: begin
				state_nx = ccag_pkg::ST_IDLE;
			end
			default: begin
				state_nx = ccag_pkg::ST_IDLE;
			end
		endcase
		if (cfg_we) state_nx = ccag_pkg::ST_LOAD;
	end

	// Derived geometry; reset values match the reset dimensions (no crop).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q  <= ccag_pkg::DIM_RESET;
			h_eff_q  <= ccag_pkg::DIM_RESET;
			den_q    <= ccag_pkg::DIM_RESET;
			crop_x_q <= '0;
			crop_y_q <= '0;
		end else if (state_q == ccag_pkg::ST_LOAD && !cfg_we) begin
			w_eff_q <= w_use;
			h_eff_q <= h_use;
			den_q   <= (w_use < h_use) ? w_use : h_use;
		end else if (state_q == ccag_pkg::ST_FINISH && !cfg_we) begin
			crop_x_q <= CROP_W'(up_x_less >> 1);
			crop_y_q <= CROP_W'(up_y_less >> 1);
		end
	end

	// Divider working registers.
	always_ff @(posedge clk) begin
		if (state_q == ccag_pkg::ST_LOAD) begin
			num_x_q <= UP_W'(UP_W'(w_use) * UP_W'(TILE_SIZE));
			num_y_q <= UP_W'(UP_W'(h_use) * UP_W'(TILE_SIZE));
			rem_x_q <= '0;
			rem_y_q <= '0;
			cnt_q   <= CNT_W'(UP_W - 1);
		end else if (state_q == ccag_pkg::ST_DIV) begin
			num_x_q <= {num_x_q[UP_W-2:0], ge_x};
			num_y_q <= {num_y_q[UP_W-2:0], ge_y};
			rem_x_q <= ge_x ? DW'(trial_x - {1'b0, den_q}) : DW'(trial_x);
			rem_y_q <= ge_y ? DW'(trial_y - {1'b0, den_q}) : DW'(trial_y);
			cnt_q   <= cnt_q - CNT_W'(1);
		end
	end

	assign w_eff  = w_eff_q;
	assign h_eff  = h_eff_q;
	assign den    = den_q;
	assign crop_x = crop_x_q;
	assign crop_y = crop_y_q;

endmodule

FILE: sv/ccag_axis_map.sv
// ----------------------------------------------------------------------------
// ccag_axis_map: five-stage mapping of one output coordinate to the source
// Adds the crop offset, scales by the denominator, divides by the tile size
// through a reciprocal product with one correction step, and clamps.
// ----------------------------------------------------------------------------
module ccag_axis_map #(
	parameter int TILE_SIZE = 80
) (
	input  logic                       clk,
	input  logic [5:1]                 adv,
	input  logic [ccag_pkg::DIM_W-1:0] coord,
	input  logic [$clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1)-1:0] crop,
	input  logic [ccag_pkg::DIM_W-1:0] den,
	input  logic [ccag_pkg::DIM_W-1:0] len,
	output logic [ccag_pkg::DIM_W-1:0] src
);

	localparam int DW     = ccag_pkg::DIM_W;
	localparam int CROP_W = $clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1);
	localparam int SUM_W  = $clog2(ccag_pkg::DIM_MAX + ((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2 + 1);
	localparam int PROD_W = SUM_W + DW;
	localparam longint RECIP = (64'd1 << PROD_W) / TILE_SIZE;
	localparam int RCP_W  = $clog2(RECIP + 1);
	localparam int QW     = $clog2(((64'd1 << PROD_W) / TILE_SIZE) + 1);
	localparam int FULL_W = PROD_W + RCP_W;

	logic [SUM_W-1:0]  sum_s1;
	logic [PROD_W-1:0] prod_s2, prod_s3, prod_s4;
	logic [QW-1:0]     qe_s3, qe_s4;
	logic [PROD_W-1:0] qt_s4;
	logic [DW-1:0]     src_s5;

	logic [FULL_W-1:0] full_prod;
	logic [PROD_W-1:0] rem;
	logic [QW-1:0]     quo;

	// Estimate is the true quotient or one below it.
	assign full_prod = FULL_W'(prod_s2) * FULL_W'(RECIP);

	// Correction and clamp to the last source pixel.
	assign rem = prod_s4 - qt_s4;
	assign quo = (rem >= PROD_W'(TILE_SIZE)) ? qe_s4 + QW'(1) : qe_s4;

	always_ff @(posedge clk) begin
		// Stage 1: shift into the centered crop.
		if (adv[1]) sum_s1 <= SUM_W'(coord) + SUM_W'(crop);
		// Stage 2: scale by the short side.
		if (adv[2]) prod_s2 <= PROD_W'(sum_s1) * PROD_W'(den);
		// Stage 3: reciprocal product.
		if (adv[3]) begin
			qe_s3   <= QW'(full_prod >> PROD_W);
			prod_s3 <= prod_s2;
		end
		// Stage 4: multiply the estimate back.
		if (adv[4]) begin
			qt_s4   <= PROD_W'(PROD_W'(qe_s3) * PROD_W'(TILE_SIZE));
			qe_s4   <= qe_s3;
			prod_s4 <= prod_s3;
		end
		// Stage 5: correct and clamp.
		if (adv[5]) begin
			src_s5 <= (quo >= QW'(len)) ? len - DW'(1) : DW'(quo);
		end
	end

	assign src = src_s5;

endmodule

FILE: sv/cover_crop_address_generator.sv
// ----------------------------------------------------------------------------
// cover_crop_address_generator: nearest-neighbor center crop addressing
// Maps each output tile pixel to the source pixel it samples and its linear
// index in the source image.
//
//  Port group   Dir  Contents
//  s_axis_*     in   out_x, out_y of one tile pixel
//  m_axis_*     out  src_x, src_y, src_index of the sampled pixel
//  cfg_*        in   src_width (index 0), src_height (index 1)
//
// One coordinate is accepted per cycle while not busy and not stalled; each
// result passes the six register stages of the mapping pipeline. A register
// write starts the crop offset sequencer, which holds s_axis_tready low in
// load, UP_W-bit divide and finish (UP_W: width of src*TILE_SIZE, 14 at 80).
// After reset the offsets already match the reset dimensions; no pass runs.
// A stalled output stage fills the bubbles upstream before input stops.
// ----------------------------------------------------------------------------
module cover_crop_address_generator #(
	parameter int TILE_SIZE = 80
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Fields from bit 0 up: out_x[6:0], out_y[13:7], zero pad.
	input  logic [ccag_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Fields from bit 0 up: src_x[6:0], src_y[13:7], src_index[26:14], zero pad.
	output logic [ccag_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [ccag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccag_pkg::DIM_W-1:0]      cfg_data
);

	localparam int DW     = ccag_pkg::DIM_W;
	localparam int IW     = ccag_pkg::INDEX_W;
	localparam int CROP_W = $clog2(((ccag_pkg::DIM_MAX-1)*TILE_SIZE)/2+1);
	localparam int NSTG   = 6;

	logic              busy;
	logic [DW-1:0]     w_eff, h_eff, den;
	logic [CROP_W-1:0] crop_x, crop_y;

	logic [NSTG:1]     vld_q;
	logic [NSTG:1]     adv;
	logic [NSTG-1:0]   vld_in;
	logic [DW-1:0]     sx_s5, sy_s5;
	logic [DW-1:0]     src_x_s6, src_y_s6;
	logic [IW-1:0]     src_index_s6;

	ccag_geometry #(
		.TILE_SIZE(TILE_SIZE)
	) u_geometry (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.busy     (busy),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.den      (den),
		.crop_x   (crop_x),
		.crop_y   (crop_y)
	);

	// A stage takes new data when it is empty or its successor moves on.
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
		vld_in[0] = s_axis_tvalid && !busy;
		for (int i = 1; i < NSTG; i++) begin
			vld_in[i] = vld_q[i];
		end
	end

	assign s_axis_tready = adv[1] && !busy;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NSTG; i++) begin
				if (adv[i]) vld_q[i] <= vld_in[i-1];
			end
		end
	end

	ccag_axis_map #(
		.TILE_SIZE(TILE_SIZE)
	) u_map_x (
		.clk  (clk),
		.adv  (adv[5:1]),
		.coord(s_axis_tdata[DW-1:0]),
		.crop (crop_x),
		.den  (den),
		.len  (w_eff),
		.src  (sx_s5)
	);

	ccag_axis_map #(
		.TILE_SIZE(TILE_SIZE)
	) u_map_y (
		.clk  (clk),
		.adv  (adv[5:1]),
		.coord(s_axis_tdata[2*DW-1:DW]),
		.crop (crop_y),
		.den  (den),
		.len  (h_eff),
		.src  (sy_s5)
	);

	// Stage 6: linear index and output register.
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			src_x_s6     <= sx_s5;
			src_y_s6     <= sy_s5;
			src_index_s6 <= IW'(IW'(sy_s5) * IW'(w_eff) + IW'(sx_s5));
		end
	end

	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = {{(ccag_pkg::M_TDATA_W - IW - 2*DW){1'b0}},
		src_index_s6, src_y_s6, src_x_s6};

	// Input is held off while the crop offsets are being derived.
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("input accepted during crop offset derivation");

	// Results always lie inside the source image.
	a_x_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (src_x_s6 < w_eff))
		else $error("source column outside the image");

	a_y_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (src_y_s6 < h_eff))
		else $error("source row outside the image");

	// The denominator is the short side once derivation is done.
	a_den_short_side: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (den <= w_eff && den <= h_eff && (den == w_eff || den == h_eff)))
		else $error("scale denominator is not the short side");

endmodule
